### hw/rtl/gql_pkg.sv
package gql_pkg;

    localparam int GLYPH_COUNT   = 95;
    localparam int PEN_FRAC_BITS = 6;
    localparam int GLYPH_FIELDS  = 9;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_START = 2'd1,
        CMD_CHAR  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    localparam logic [2:0] REG_SCALE = 3'd0;
    localparam logic [2:0] REG_POS_X = 3'd1;
    localparam logic [2:0] REG_POS_Y = 3'd2;
    localparam logic [2:0] REG_WIN_W = 3'd3;
    localparam logic [2:0] REG_WIN_H = 3'd4;
    localparam logic [2:0] REG_GAIN_X = 3'd5;
    localparam logic [2:0] REG_GAIN_Y = 3'd6;

    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_LF  = 8'd10;
    localparam logic [7:0] CH_VT  = 8'd11;
    localparam logic [7:0] CH_FF  = 8'd12;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_FIRST = 8'd32;
    localparam logic [7:0] CH_LAST  = 8'd126;

    // Classified operation handed from the front end to the back end.
    typedef enum logic [2:0] {
        OP_START   = 3'd0,
        OP_ADV4    = 3'd1,
        OP_LF      = 3'd2,
        OP_VT      = 3'd3,
        OP_CR      = 3'd4,
        OP_ADV1    = 3'd5,
        OP_GLYPH   = 3'd6
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] glyph;
    } t_job;

endpackage

### hw/rtl/gql_ram.sv
module gql_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 855
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/gql_front.sv
module gql_front #(
    parameter int GLYPHS = gql_pkg::GLYPH_COUNT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_char_code,
    input  logic [6:0]           i_glyph_index,
    input  logic [3:0]           i_glyph_field,
    input  logic [16:0]          i_glyph_value,
    output logic                 o_we,
    output logic [$clog2(GLYPHS*gql_pkg::GLYPH_FIELDS)-1:0] o_waddr,
    output logic [16:0]          o_wdata,
    output logic                 o_job_valid,
    output gql_pkg::t_job        o_job,
    input  logic                 i_job_ready,
    input  logic                 i_back_idle
);
    import gql_pkg::*;
    localparam int AW = $clog2(GLYPHS*GLYPH_FIELDS);
    localparam logic [AW+4:0] FIELDS_W = (AW+5)'(GLYPH_FIELDS);

    // Two-entry queue towards the back end.
    t_job r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       push, pop;
    t_job       job;
    logic       job_en;
    logic [AW+4:0] addr_full;

    always_comb begin
        job_en = 1'b0;
        job    = '{op: OP_START, glyph: 8'd0};
        unique case (t_cmd'(i_command))
            CMD_START: job_en = 1'b1;
            CMD_CHAR: begin
                job_en = 1'b1;
                priority if (i_char_code == CH_TAB || i_char_code == CH_FF) begin
                    job.op = OP_ADV4;
                end else if (i_char_code == CH_LF) begin
                    job.op = OP_LF;
                end else if (i_char_code == CH_VT) begin
                    job.op = OP_VT;
                end else if (i_char_code == CH_CR) begin
                    job.op = OP_CR;
                end else if (i_char_code < CH_FIRST || i_char_code > CH_LAST) begin
                    job.op = OP_ADV1;
                end else begin
                    job.op    = OP_GLYPH;
                    job.glyph = i_char_code - CH_FIRST;
                end
            end
            CMD_LOAD, CMD_NONE: job_en = 1'b0;
            default: job_en = 1'b0;
        endcase
    end

    // A load waits until nothing queued or in the back end can still read the table.
    assign o_ready = (r_cnt != 2'd2) &&
                     ((t_cmd'(i_command) != CMD_LOAD) || (r_cnt == 2'd0 && i_back_idle));
    assign push    = i_valid && o_ready && job_en;
    assign pop     = o_job_valid && i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd  <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_rd ^ r_cnt[0]] <= job;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assign o_job_valid = (r_cnt != 2'd0);
    assign o_job       = r_q[r_rd];

    // Table loads go straight to the memory; the back end only reads it.
    assign addr_full = {{(AW-2){1'b0}}, i_glyph_index} * FIELDS_W
                       + {{(AW+1){1'b0}}, i_glyph_field};
    assign o_we    = i_valid && o_ready && (t_cmd'(i_command) == CMD_LOAD)
                     && ({25'd0, i_glyph_index} < GLYPHS)
                     && (i_glyph_field < 4'(GLYPH_FIELDS));
    assign o_waddr = addr_full[AW-1:0];
    assign o_wdata = i_glyph_value;
endmodule

### hw/rtl/gql_back.sv
module gql_back #(
    parameter int GLYPHS    = gql_pkg::GLYPH_COUNT,
    parameter int PEN_FRAC  = gql_pkg::PEN_FRAC_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  gql_pkg::t_job i_job,
    output logic          o_job_ready,
    output logic [$clog2(GLYPHS*gql_pkg::GLYPH_FIELDS)-1:0] o_raddr,
    input  logic [16:0]   i_rdata,
    input  logic [15:0]   i_scale,
    input  logic [15:0]   i_pos_x,
    input  logic [15:0]   i_pos_y,
    input  logic [13:0]   i_win_w,
    input  logic [13:0]   i_win_h,
    input  logic [25:0]   i_gain_x,
    input  logic [25:0]   i_gain_y,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [64:0]   o_data
);
    import gql_pkg::*;
    localparam int AW = $clog2(GLYPHS*GLYPH_FIELDS);
    localparam int NS = PEN_FRAC + 11;
    localparam logic [AW+4:0] FIELDS_W = (AW+5)'(GLYPH_FIELDS);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_MUL, S_ACC, S_START1, S_START2, S_NDC,
        S_EMIT, S_ADV
    } t_state;

    t_state r_state;
    t_op    r_op;
    logic [7:0] r_glyph;
    logic [3:0] r_fld;        // field whose read is in flight
    logic [3:0] r_got;        // field whose data is on i_rdata
    logic       r_rvalid;
    logic signed [31:0] r_pen_x, r_pen_y, r_org_x;
    logic signed [16:0] r_m [9];
    logic signed [47:0] r_prod;
    logic signed [40:0] r_cx [2];
    logic signed [40:0] r_cy [2];
    logic [15:0] r_vx [2];
    logic [15:0] r_vy [2];
    logic [1:0]  r_k;
    logic [1:0]  r_ci;        // corner index for conversions
    logic        r_out_valid;
    logic [64:0] r_out;
    logic signed [67:0] r_nprod;

    logic signed [47:0] metric_p;
    logic signed [47:0] rnd18;
    logic signed [47:0] sp;
    logic signed [47:0] sum;
    logic signed [31:0] sat_sum;
    logic [AW+4:0] raddr_full;
    logic signed [67:0] nround;
    logic signed [67:0] nval;
    logic [15:0] nsat;
    logic signed [31:0] start_s;
    logic signed [47:0] start_p;

    function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
        if (v > 48'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
        if (v < -48'sh8000_0000) return -32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic [15:0] tex(input logic signed [16:0] v);
        return v[16] ? 16'd0 : v[15:0];
    endfunction

    // Scale in pen format, rounded half up.
    always_comb begin
        if (PEN_FRAC >= 6) begin
            sp = $signed({32'd0, i_scale}) <<< (PEN_FRAC - 6);
        end else begin
            sp = ($signed({32'd0, i_scale}) + (48'sd1 <<< (5 - PEN_FRAC))) >>> (6 - PEN_FRAC);
        end
    end

    // Metric times scale (times four for tabs and form feeds), rounded to pen format.
    assign metric_p = r_prod <<< PEN_FRAC;
    assign rnd18    = (metric_p + 48'sd131072) >>> 18;
    assign sum      = $signed({{16{r_pen_x[31]}}, r_pen_x}) + rnd18;
    assign sat_sum  = sat32(sum);

    // Start-of-text multiply on the current axis.
    assign start_s = (r_ci[0] ? $signed({{16{i_pos_y[15]}}, i_pos_y})
                              : $signed({{16{i_pos_x[15]}}, i_pos_x})) + 32'sd8192;
    assign start_p = start_s * $signed({34'd0, r_ci[0] ? i_win_h : i_win_w});

    assign nround = (r_nprod + (68'sd1 <<< (NS - 1))) >>> NS;
    assign nval   = nround - 68'sd8192;
    assign nsat   = (nval > 68'sd32767) ? 16'h7FFF :
                    (nval < -68'sd32768) ? 16'h8000 : nval[15:0];

    assign raddr_full = {{(AW-2){1'b0}}, r_glyph[6:0]} * FIELDS_W
                        + {{(AW+1){1'b0}}, r_fld};
    assign o_raddr    = raddr_full[AW-1:0];
    assign o_job_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    // Sequencer: start and pen moves, or read fields, multiply one metric a cycle, convert, emit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pen_x     <= '0;
            r_pen_y     <= '0;
            r_org_x     <= '0;
            r_out_valid <= 1'b0;
            r_rvalid    <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            // A read issued in S_READ shows its data in the next cycle.
            r_rvalid <= (r_state == S_READ);
            if (r_rvalid) begin
                r_m[r_got] <= $signed(i_rdata);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_op    <= i_job.op;
                        r_glyph <= (i_job.op == OP_GLYPH) ? i_job.glyph : 8'd0;
                        r_fld   <= 4'd0;
                        r_ci    <= 2'd0;
                        unique case (i_job.op)
                            OP_START: r_state <= S_START1;
                            OP_LF: begin
                                r_pen_y <= sat32($signed({{16{r_pen_y[31]}}, r_pen_y}) - sp);
                                r_pen_x <= r_org_x;
                            end
                            OP_VT: r_pen_y <= sat32($signed({{16{r_pen_y[31]}}, r_pen_y}) - sp);
                            OP_CR: r_pen_x <= r_org_x;
                            OP_ADV4, OP_ADV1, OP_GLYPH: r_state <= S_READ;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_READ: begin
                    // Issue one field read a cycle; a glyph needs all nine.
                    r_got <= r_fld;
                    if (r_op == OP_GLYPH && r_fld != 4'd8) begin
                        r_fld <= r_fld + 4'd1;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (r_op == OP_GLYPH) begin
                        if (r_m[1] == r_m[3] || r_m[2] == r_m[4]) begin
                            r_ci    <= 2'd0;
                            r_state <= S_ADV;
                            r_prod  <= $signed({{31{r_m[0][16]}}, r_m[0]}) * $signed({32'd0, i_scale});
                        end else begin
                            r_ci    <= 2'd1;
                            r_prod  <= $signed({{31{r_m[1][16]}}, r_m[1]}) * $signed({32'd0, i_scale});
                            r_state <= S_ACC;
                        end
                    end else begin
                        // The space advance is still on the read port this cycle.
                        r_prod  <= ($signed({{31{i_rdata[16]}}, i_rdata}) * $signed({32'd0, i_scale}))
                                   <<< ((r_op == OP_ADV4) ? 2 : 0);
                        r_state <= S_ADV;
                    end
                end
                S_ACC: begin
                    // Corner positions, one metric a cycle (left, bottom, right, top).
                    unique case (r_ci)
                        2'd1: r_cx[0] <= sum[40:0];
                        2'd2: r_cy[0] <= sum[40:0] - $signed({{9{r_pen_x[31]}}, r_pen_x})
                                         + $signed({{9{r_pen_y[31]}}, r_pen_y});
                        2'd3: r_cx[1] <= sum[40:0];
                        2'd0: r_cy[1] <= sum[40:0] - $signed({{9{r_pen_x[31]}}, r_pen_x})
                                         + $signed({{9{r_pen_y[31]}}, r_pen_y});
                        default: ;
                    endcase
                    if (r_ci == 2'd0) begin
                        r_state <= S_NDC;
                        r_nprod <= r_cx[0] * $signed({42'd0, i_gain_x});
                        r_ci    <= 2'd1;
                    end else begin
                        r_prod <= $signed({{31{r_m[3'(r_ci) + 3'd1][16]}}, r_m[3'(r_ci) + 3'd1]})
                                  * $signed({32'd0, i_scale});
                        r_ci   <= r_ci + 2'd1;
                    end
                end
                S_NDC: begin
                    // One corner product a cycle, rounded and saturated the next.
                    unique case (r_ci)
                        2'd1: begin
                            r_vx[0] <= nsat;
                            r_nprod <= r_cx[1] * $signed({42'd0, i_gain_x});
                        end
                        2'd2: begin
                            r_vx[1] <= nsat;
                            r_nprod <= r_cy[0] * $signed({42'd0, i_gain_y});
                        end
                        2'd3: begin
                            r_vy[0] <= nsat;
                            r_nprod <= r_cy[1] * $signed({42'd0, i_gain_y});
                        end
                        2'd0: begin
                            r_vy[1] <= nsat;
                            r_state <= S_EMIT;
                            r_k     <= 2'd0;
                        end
                        default: ;
                    endcase
                    r_ci <= r_ci + 2'd1;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out <= {(r_k == 2'd3),
                                  tex(r_k[1] ? r_m[8] : r_m[6]),
                                  tex(r_k[0] ? r_m[7] : r_m[5]),
                                  r_k[1] ? r_vy[1] : r_vy[0],
                                  r_k[0] ? r_vx[1] : r_vx[0]};
                        r_k <= r_k + 2'd1;
                        if (r_k == 2'd3) begin
                            r_prod  <= $signed({{31{r_m[0][16]}}, r_m[0]}) * $signed({32'd0, i_scale});
                            r_state <= S_ADV;
                        end
                    end
                end
                S_ADV: begin
                    r_pen_x <= sat_sum;
                    r_state <= S_IDLE;
                end
                S_START1: begin
                    // x axis: round to pen format, take off the scale.
                    r_pen_x <= sat32((((start_p <<< PEN_FRAC) + 48'sd8192) >>> 14) - sp);
                    r_org_x <= sat32((((start_p <<< PEN_FRAC) + 48'sd8192) >>> 14) - sp);
                    r_ci    <= 2'd1;
                    r_state <= S_START2;
                end
                S_START2: begin
                    r_pen_y <= sat32(((start_p <<< PEN_FRAC) + 48'sd8192) >>> 14);
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### hw/rtl/glyph_quad_layout.sv
// Text layout engine: command items load the glyph table (one field per item), start a
// text or lay out one character byte. Each drawable glyph yields four vertex items, the
// last flagged by tlast. In the back-end sequencer a drawn character takes nine table
// reads one per cycle, four corner metric products one per cycle, four NDC conversions
// one per cycle, four vertex items and the pen advance (an empty quad: the reads and the
// advance). Tab, form feed and other non-printing bytes take a space-advance read, a
// multiply and the advance, a start an x-axis and a y-axis step, line feed, vertical tab
// and CR only the idle state, with a two-item queue in between. A load is accepted only
// once queue and back end are empty, so queued characters always see the table as on arrival.
module glyph_quad_layout #(
    parameter int GLYPH_COUNT   = gql_pkg::GLYPH_COUNT,
    parameter int PEN_FRAC_BITS = gql_pkg::PEN_FRAC_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // command[1:0], char_code[9:2], glyph_index[16:10], glyph_field[20:17],
    // glyph_value[37:21], zero pad to 40
    input  logic [39:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // vertex_x[15:0], vertex_y[31:16], tex_u[47:32], tex_v[63:48]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [25:0] i_cfg_data
);
    import gql_pkg::*;
    localparam int AW = $clog2(GLYPH_COUNT*GLYPH_FIELDS);

    logic [15:0] r_scale, r_pos_x, r_pos_y;
    logic [13:0] r_win_w, r_win_h;
    logic [25:0] r_gain_x, r_gain_y;
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [16:0] wdata, rdata;
    logic job_valid, job_ready;
    t_job job;
    logic [64:0] out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale  <= 16'd3072;
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_win_w  <= 14'd1024;
            r_win_h  <= 14'd1024;
            r_gain_x <= 26'd32768;
            r_gain_y <= 26'd32768;
        end else if (i_cfg_we) begin
            priority case (i_cfg_index)
                REG_SCALE:  r_scale  <= i_cfg_data[15:0];
                REG_POS_X:  r_pos_x  <= i_cfg_data[15:0];
                REG_POS_Y:  r_pos_y  <= i_cfg_data[15:0];
                REG_WIN_W:  r_win_w  <= i_cfg_data[13:0];
                REG_WIN_H:  r_win_h  <= i_cfg_data[13:0];
                REG_GAIN_X: r_gain_x <= i_cfg_data;
                REG_GAIN_Y: r_gain_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gql_front #(.GLYPHS(GLYPH_COUNT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_command(s_axis_tdata[1:0]), .i_char_code(s_axis_tdata[9:2]),
        .i_glyph_index(s_axis_tdata[16:10]), .i_glyph_field(s_axis_tdata[20:17]),
        .i_glyph_value(s_axis_tdata[37:21]),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_job_valid(job_valid), .o_job(job), .i_job_ready(job_ready),
        .i_back_idle(job_ready)
    );

    gql_ram #(.WIDTH(17), .DEPTH(GLYPH_COUNT*GLYPH_FIELDS)) u_table (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    gql_back #(.GLYPHS(GLYPH_COUNT), .PEN_FRAC(PEN_FRAC_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .i_job(job), .o_job_ready(job_ready),
        .o_raddr(raddr), .i_rdata(rdata),
        .i_scale(r_scale), .i_pos_x(r_pos_x), .i_pos_y(r_pos_y),
        .i_win_w(r_win_w), .i_win_h(r_win_h), .i_gain_x(r_gain_x), .i_gain_y(r_gain_y),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(out)
    );

    assign m_axis_tdata = out[63:0];
    assign m_axis_tlast = out[64];
endmodule

### hw/rtl/gql_checker.sv
module gql_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

    // After a quad's last vertex the next item is not immediately another last.
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !(m_axis_tvalid && m_axis_tlast))
        else $error("two last vertices in a row");

    // Results never appear straight out of reset.
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result after reset");

    // An offered input item stays offered until it is taken.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid)
        else $error("input item withdrawn before acceptance");
endmodule

bind glyph_quad_layout gql_checker u_checker (
    .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

### tb/sv/glyph_quad_layout_tb.sv
`timescale 1ns / 100ps

module glyph_quad_layout_tb;
    import gql_pkg::*;

    localparam int TABLE_DEPTH = GLYPH_COUNT * GLYPH_FIELDS;
    localparam int PF          = PEN_FRAC_BITS;
    localparam int NDC_ONE     = 8192;
    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE      = 60;

    // Glyph fields in table order.
    localparam logic [3:0] FLD_ADV = 4'd0;
    localparam logic [3:0] FLD_QL  = 4'd1;
    localparam logic [3:0] FLD_QB  = 4'd2;
    localparam logic [3:0] FLD_QR  = 4'd3;
    localparam logic [3:0] FLD_QT  = 4'd4;
    localparam logic [3:0] FLD_AL  = 4'd5;
    localparam logic [3:0] FLD_AB  = 4'd6;
    localparam logic [3:0] FLD_AR  = 4'd7;
    localparam logic [3:0] FLD_AT  = 4'd8;

    typedef struct {
        t_cmd        cmd;
        logic [7:0]  ch;
        logic [6:0]  gi;
        logic [3:0]  gf;
        logic [16:0] val;
        bit          drain;
    } t_text_item;

    typedef struct {
        logic [15:0] vx;
        logic [15:0] vy;
        logic [15:0] tu;
        logic [15:0] tv;
        logic        last;
    } t_vertex;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [25:0] i_cfg_data = '0;

    glyph_quad_layout dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Layout state mirrored from the block.
    longint     metrics[TABLE_DEPTH];
    bit         loaded[TABLE_DEPTH];
    int         pen_x, pen_y, origin_x;
    logic [15:0] cur_scale = 16'd3072, cur_pos_x = '0, cur_pos_y = '0;
    logic [13:0] cur_win_w = 14'd1024, cur_win_h = 14'd1024;
    logic [25:0] cur_gain_x = 26'd32768, cur_gain_y = 26'd32768;

    t_text_item pending_items[$];
    t_vertex    vertices_due[$];
    int errors = 0, items_sent = 0, vertices_seen = 0, quads_drawn = 0;
    bit quiet = 1'b0;
    int idle_cycles = 0;

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic int clamp32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return int'(v);
    endfunction

    function automatic longint scale_in_pen();
        return round_shift(longint'(cur_scale) * (longint'(1) << PF), 6);
    endfunction

    function automatic longint scaled_metric(longint m, longint times);
        return round_shift(m * longint'(cur_scale) * times * (longint'(1) << PF), 18);
    endfunction

    function automatic logic [15:0] to_ndc(longint corner, logic [25:0] gain);
        longint v;
        v = round_shift(corner * longint'(gain), PF + 11) - NDC_ONE;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [15:0] to_tex(longint v);
        if (v < 0) return 16'd0;
        if (v > 65535) return 16'hFFFF;
        return v[15:0];
    endfunction

    function automatic longint metric(int g, logic [3:0] f);
        return metrics[g * GLYPH_FIELDS + f];
    endfunction

    function automatic bit glyph_ready(int g);
        for (int f = 0; f < GLYPH_FIELDS; f++)
            if (!loaded[g * GLYPH_FIELDS + f]) return 1'b0;
        return 1'b1;
    endfunction

    // Apply one accepted item to the mirrored state and queue the vertices it draws.
    task automatic lay_out_item(t_text_item it);
        int g;
        longint ql, qb, qr, qt, sx, sy;
        logic [15:0] vx[2], vy[2], tu[2], tv[2];
        t_vertex v;
        case (it.cmd)
            CMD_LOAD: begin
                if (it.gi < GLYPH_COUNT && it.gf < GLYPH_FIELDS)
                    metrics[it.gi * GLYPH_FIELDS + it.gf] = longint'(signed'(it.val));
            end
            CMD_START: begin
                sx = (longint'(signed'(cur_pos_x)) + 8192) * longint'(cur_win_w);
                sy = (longint'(signed'(cur_pos_y)) + 8192) * longint'(cur_win_h);
                pen_x = clamp32(round_shift(sx * (longint'(1) << PF), 14) - scale_in_pen());
                pen_y = clamp32(round_shift(sy * (longint'(1) << PF), 14));
                origin_x = pen_x;
            end
            CMD_CHAR: begin
                if (it.ch == CH_TAB || it.ch == CH_FF) begin
                    pen_x = clamp32(longint'(pen_x) + scaled_metric(metric(0, FLD_ADV), 4));
                end else if (it.ch == CH_LF) begin
                    pen_y = clamp32(longint'(pen_y) - scale_in_pen());
                    pen_x = origin_x;
                end else if (it.ch == CH_VT) begin
                    pen_y = clamp32(longint'(pen_y) - scale_in_pen());
                end else if (it.ch == CH_CR) begin
                    pen_x = origin_x;
                end else if (it.ch < CH_FIRST || it.ch > CH_LAST) begin
                    pen_x = clamp32(longint'(pen_x) + scaled_metric(metric(0, FLD_ADV), 1));
                end else begin
                    g  = it.ch - CH_FIRST;
                    ql = metric(g, FLD_QL);
                    qb = metric(g, FLD_QB);
                    qr = metric(g, FLD_QR);
                    qt = metric(g, FLD_QT);
                    if (ql != qr && qb != qt) begin
                        vx[0] = to_ndc(longint'(pen_x) + scaled_metric(ql, 1), cur_gain_x);
                        vx[1] = to_ndc(longint'(pen_x) + scaled_metric(qr, 1), cur_gain_x);
                        vy[0] = to_ndc(longint'(pen_y) + scaled_metric(qb, 1), cur_gain_y);
                        vy[1] = to_ndc(longint'(pen_y) + scaled_metric(qt, 1), cur_gain_y);
                        tu[0] = to_tex(metric(g, FLD_AL));
                        tv[0] = to_tex(metric(g, FLD_AB));
                        tu[1] = to_tex(metric(g, FLD_AR));
                        tv[1] = to_tex(metric(g, FLD_AT));
                        for (int k = 0; k < 4; k++) begin
                            v.vx = vx[k & 1];
                            v.vy = vy[k >> 1];
                            v.tu = tu[k & 1];
                            v.tv = tv[k >> 1];
                            v.last = (k == 3);
                            vertices_due.insert(vertices_due.size(), v);
                        end
                        quads_drawn++;
                    end
                    pen_x = clamp32(longint'(pen_x) + scaled_metric(metric(g, FLD_ADV), 1));
                end
            end
            default: ;
        endcase
    endtask

    // Sender: offers pending items with random gaps (none when quiet); a drain item waits for all vertices.
    int gap_left = 0;
    t_text_item offered;
    always @(posedge i_clk) begin
        logic next_valid;
        t_text_item it;
        next_valid = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                lay_out_item(offered);
                items_sent++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0 &&
                             !(pending_items[0].drain && vertices_due.size() > 0)) begin
                    it = pending_items.pop_front();
                    offered <= it;
                    s_axis_tdata <= {2'b00, it.val, it.gf, it.gi, it.ch, it.cmd};
                    next_valid = 1'b1;
                    gap_left = quiet ? 0 : $urandom_range(0, 8);
                end
            end
        end
        s_axis_tvalid <= next_valid;
    end

    // Receiver: random stalls per vertex (none when quiet) and one long hold-off to back the block up.
    int rx_gap = 0, rx_hold = 0;
    bit held_once = 1'b0;
    always @(posedge i_clk) begin
        t_vertex want;
        logic next_ready;
        next_ready = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                vertices_seen++;
                if (vertices_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("vertex with none due: data %h last %b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    want = vertices_due.pop_front();
                    if (m_axis_tdata[15:0] !== want.vx || m_axis_tdata[31:16] !== want.vy ||
                        m_axis_tdata[47:32] !== want.tu || m_axis_tdata[63:48] !== want.tv ||
                        m_axis_tlast !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display("vertex %0d mismatch: want x %h y %h u %h v %h last %b,",
                                     vertices_seen, want.vx, want.vy, want.tu, want.tv,
                                     want.last, " got x %h y %h u %h v %h last %b",
                                     m_axis_tdata[15:0], m_axis_tdata[31:16],
                                     m_axis_tdata[47:32], m_axis_tdata[63:48], m_axis_tlast);
                    end
                end
                rx_gap = quiet ? 0 : $urandom_range(0, 8);
                if (!held_once && vertices_seen == 40) begin
                    rx_hold = 400;
                    held_once = 1'b1;
                end
            end
            if (rx_hold > 0)
                rx_hold--;
            else if (rx_gap > 0)
                rx_gap--;
            else
                next_ready = 1'b1;
        end
        m_axis_tready <= next_ready;
    end

    // Watchdog on cycles without any handshake or register write.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: %0d vertices still due", vertices_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [25:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        case (idx)
            REG_SCALE:  cur_scale  = value[15:0];
            REG_POS_X:  cur_pos_x  = value[15:0];
            REG_POS_Y:  cur_pos_y  = value[15:0];
            REG_WIN_W:  cur_win_w  = value[13:0];
            REG_WIN_H:  cur_win_h  = value[13:0];
            REG_GAIN_X: cur_gain_x = value;
            REG_GAIN_Y: cur_gain_y = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push(t_cmd cmd, logic [7:0] ch, logic [6:0] gi, logic [3:0] gf,
                        logic [16:0] val, bit drain);
        t_text_item it;
        it = '{cmd, ch, gi, gf, val, drain};
        if (cmd == CMD_LOAD && gi < GLYPH_COUNT && gf < GLYPH_FIELDS)
            loaded[gi * GLYPH_FIELDS + gf] = 1'b1;
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic load_glyph(int g, logic [16:0] f[9]);
        for (int k = 0; k < GLYPH_FIELDS; k++)
            push(CMD_LOAD, 8'($urandom), 7'(g), 4'(k), f[k], 1'b0);
    endtask

    // Metric draws: mostly around one em, now and then anything the field holds.
    function automatic logic [16:0] any_metric();
        if ($urandom_range(0, 9) == 0) return 17'($urandom);
        return 17'($urandom_range(0, 12288) - 4096);
    endfunction

    task automatic random_glyph();
        logic [16:0] f[9];
        f[0] = any_metric();
        for (int k = 1; k <= 4; k++) f[k] = any_metric();
        if ($urandom_range(0, 7) == 0) f[3] = f[1];
        if ($urandom_range(0, 7) == 0) f[4] = f[2];
        for (int k = 5; k < 9; k++) f[k] = 17'($urandom);
        load_glyph($urandom_range(0, GLYPH_COUNT - 1), f);
    endtask

    task automatic drawable_char();
        int g;
        do g = $urandom_range(0, GLYPH_COUNT - 1); while (!glyph_ready(g));
        push(CMD_CHAR, 8'(g + CH_FIRST), 7'($urandom), 4'($urandom), 17'($urandom), 1'b0);
    endtask

    // Random part of one phase: glyph definitions and text, with some noise.
    task automatic random_text(int count);
        int pick, start_size;
        logic [7:0] c;
        bit drained;
        start_size = pending_items.size();
        drained = 1'b0;
        push(CMD_START, 8'($urandom), 7'($urandom), 4'($urandom), 17'($urandom), 1'b0);
        while (pending_items.size() - start_size < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                random_glyph();
            end else if (pick < 70) begin
                drawable_char();
            end else if (pick < 82) begin
                do c = 8'($urandom); while (c >= CH_FIRST && c <= CH_LAST);
                push(CMD_CHAR, c, 7'($urandom), 4'($urandom), 17'($urandom), 1'b0);
            end else if (pick < 88) begin
                push(CMD_START, 8'($urandom), 7'($urandom), 4'($urandom), 17'($urandom),
                     1'b0);
            end else if (pick < 94) begin
                // Loads that miss the table: index past the last glyph or unused field.
                push(CMD_LOAD, 8'($urandom), 7'($urandom_range(GLYPH_COUNT, 127)),
                     4'($urandom), 17'($urandom), 1'b0);
                push(CMD_LOAD, 8'($urandom), 7'($urandom), 4'($urandom_range(9, 15)),
                     17'($urandom), 1'b0);
            end else begin
                push(CMD_NONE, 8'($urandom), 7'($urandom), 4'($urandom), 17'($urandom), 1'b0);
            end
            if (!drained && pending_items.size() - start_size >= count / 2) begin
                push(CMD_CHAR, CH_CR, '0, '0, '0, 1'b1);
                drained = 1'b1;
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || s_axis_tvalid || vertices_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic configure(logic [25:0] r[7]);
        for (int k = 0; k < 7; k++)
            write_reg(3'(k), r[k]);
    endtask

    initial begin
        logic [16:0] f[9];
        logic [25:0] cfg[7];
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            metrics[k] = 0;
            loaded[k] = 1'b0;
        end
        pen_x = 0;
        pen_y = 0;
        origin_x = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed text: space has an empty quad, 'A' carries extreme metrics.
        f = '{17'd2048, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0};
        load_glyph(0, f);
        f = '{17'h1FFFF, 17'h18000, 17'h1FF9C, 17'h0FFFF, 17'd4096,
              17'h1FFFF, 17'd0, 17'h0FFFF, 17'd32768};
        load_glyph(33, f);
        push(CMD_START, '0, '0, '0, '0, 1'b0);
        push(CMD_CHAR, 8'd65, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_FIRST, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_TAB, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_FF, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_LF, '0, '0, '0, 1'b0);
        push(CMD_CHAR, 8'd65, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_VT, '0, '0, '0, 1'b0);
        push(CMD_CHAR, CH_CR, '0, '0, '0, 1'b0);
        push(CMD_CHAR, 8'd255, '0, '0, '0, 1'b0);
        push(CMD_CHAR, 8'd0, '0, '0, '0, 1'b0);
        push(CMD_NONE, 8'd65, 7'h7F, 4'hF, 17'h1FFFF, 1'b0);
        push(CMD_LOAD, '0, 7'd127, FLD_ADV, 17'h1FFFF, 1'b0);
        push(CMD_LOAD, '0, 7'd33, 4'd15, 17'h1FFFF, 1'b0);
        push(CMD_CHAR, 8'd65, '0, '0, '0, 1'b0);
        for (int k = 0; k < 6; k++) random_glyph();
        random_text(30);
        wait_idle();

        // Ordinary screen, no idling on either side.
        quiet = 1'b1;
        cfg = '{26'd4096, 26'h3C000, 26'd8000, 26'd1920, 26'd1080, 26'd17476, 26'd31069};
        configure(cfg);
        random_text(65);
        wait_idle();
        quiet = 1'b0;

        // Extreme settings: largest scale, opposite position extremes, zero y gain.
        cfg = '{26'hFFFF, 26'h7FFF, 26'h8000, 26'd8192, 26'd1, 26'd33554432, 26'd0};
        configure(cfg);
        random_text(55);
        wait_idle();

        // Extreme settings: zero scale, mirrored position extremes, zero x gain.
        cfg = '{26'd0, 26'h8000, 26'h7FFF, 26'd1, 26'd8192, 26'd0, 26'd4096};
        configure(cfg);
        random_text(50);
        wait_idle();

        cfg = '{26'd2000, 26'd0, 26'd0, 26'd800, 26'd600, 26'd41943, 26'd55924};
        configure(cfg);
        random_text(75);
        wait_idle();

        $display("Sent %0d items over five register settings; %0d quads, %0d vertices checked.",
                 items_sent, quads_drawn, vertices_seen);
        if (errors == 0 && vertices_due.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("%0d mismatches, %0d vertices never seen", errors, vertices_due.size());
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/gql_pkg.sv
hw/rtl/gql_ram.sv
hw/rtl/gql_front.sv
hw/rtl/gql_back.sv
hw/rtl/glyph_quad_layout.sv
hw/rtl/gql_checker.sv
tb/sv/glyph_quad_layout_tb.sv
